>>> src/wrd_pkg.sv
// shared types, constants and microcode table of the window rise detector
`default_nettype none

package wrd_pkg;

  // field widths
  localparam int INST_W  = 48;
  localparam int TIME_W  = 27;
  localparam int PRICE_W = 32;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 48;

  localparam logic [CFG_IDX_W-1:0] REG_INSTRUMENT_CODE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SPAN_MS  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RISE_THRESHOLD  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INITIAL_LOW     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_ORDERS     = 3'd4;

  // register reset values
  localparam logic [TIME_W-1:0]  SPAN_RESET      = 27'd300000;
  localparam logic [PRICE_W-1:0] THRESHOLD_RESET = 32'd500;
  localparam logic [PRICE_W-1:0] INIT_LOW_RESET  = 32'd10000000;

  // one stored tick
  typedef struct packed {
    logic [TIME_W-1:0]  tick_time;
    logic [PRICE_W-1:0] tick_price;
  } tick_entry_t;

  // microcode step addresses
  typedef logic [3:0] step_t;

  localparam step_t S_WAIT      = 4'd0;
  localparam step_t S_CHK_CMD   = 4'd1;
  localparam step_t S_CHK_INST  = 4'd2;
  localparam step_t S_EXP_RD    = 4'd3;
  localparam step_t S_EXP_CHK   = 4'd4;
  localparam step_t S_ST_RD     = 4'd5;
  localparam step_t S_ST_CHK    = 4'd6;
  localparam step_t S_ST_APP    = 4'd7;
  localparam step_t S_ST_OVR    = 4'd8;
  localparam step_t S_SCAN_INIT = 4'd9;
  localparam step_t S_SCAN_RD   = 4'd10;
  localparam step_t S_SCAN_CHK  = 4'd11;
  localparam step_t S_SCAN_HIT  = 4'd12;
  localparam step_t S_RELOAD    = 4'd13;
  localparam step_t S_IGNORE    = 4'd14;
  localparam step_t S_DONE      = 4'd15;

  // datapath operations
  typedef enum logic [3:0] {
    OP_NOP       = 4'd0,
    OP_LATCH     = 4'd1,
    OP_RD_OLD    = 4'd2,
    OP_POP       = 4'd3,
    OP_RD_NEW    = 4'd4,
    OP_APPEND    = 4'd5,
    OP_OVERWRITE = 4'd6,
    OP_SCAN_INIT = 4'd7,
    OP_RD_SCAN   = 4'd8,
    OP_SCAN_STEP = 4'd9,
    OP_EMIT      = 4'd10,
    OP_CLEAR     = 4'd11,
    OP_IGNORE    = 4'd12
  } op_t;

  // jump conditions
  typedef enum logic [3:0] {
    C_NEVER     = 4'd0,
    C_ALWAYS    = 4'd1,
    C_NO_ITEM   = 4'd2,
    C_RELOAD    = 4'd3,
    C_MISMATCH  = 4'd4,
    C_EMPTY     = 4'd5,
    C_EXPIRED   = 4'd6,
    C_SAME_TIME = 4'd7,
    C_HOLD      = 4'd8,
    C_SCAN_END  = 4'd9,
    C_NO_FIRE   = 4'd10,
    C_OUT_BUSY  = 4'd11
  } cond_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    step_t target;
  } ctrl_word_t;

  // control store: jump to target when cond holds, else fall through
  // (the step counter wraps from the last step back to the wait step)
  function automatic ctrl_word_t ucode(input step_t pc);
    ctrl_word_t w;
    case (pc)
      S_WAIT:      w = '{OP_LATCH,     C_NO_ITEM,   S_WAIT};
      S_CHK_CMD:   w = '{OP_NOP,       C_RELOAD,    S_RELOAD};
      S_CHK_INST:  w = '{OP_NOP,       C_MISMATCH,  S_IGNORE};
      S_EXP_RD:    w = '{OP_RD_OLD,    C_EMPTY,     S_ST_RD};
      S_EXP_CHK:   w = '{OP_POP,       C_EXPIRED,   S_EXP_RD};
      S_ST_RD:     w = '{OP_RD_NEW,    C_EMPTY,     S_ST_APP};
      S_ST_CHK:    w = '{OP_NOP,       C_SAME_TIME, S_ST_OVR};
      S_ST_APP:    w = '{OP_APPEND,    C_ALWAYS,    S_SCAN_INIT};
      S_ST_OVR:    w = '{OP_OVERWRITE, C_NEVER,     S_WAIT};
      S_SCAN_INIT: w = '{OP_SCAN_INIT, C_HOLD,      S_DONE};
      S_SCAN_RD:   w = '{OP_RD_SCAN,   C_SCAN_END,  S_DONE};
      S_SCAN_CHK:  w = '{OP_SCAN_STEP, C_NO_FIRE,   S_SCAN_RD};
      S_SCAN_HIT:  w = '{OP_NOP,       C_ALWAYS,    S_DONE};
      S_RELOAD:    w = '{OP_CLEAR,     C_ALWAYS,    S_DONE};
      S_IGNORE:    w = '{OP_IGNORE,    C_ALWAYS,    S_DONE};
      S_DONE:      w = '{OP_EMIT,      C_OUT_BUSY,  S_DONE};
      default:     w = '{OP_NOP,       C_ALWAYS,    S_WAIT};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

>>> src/wrd_ifs.sv
// valid/ready channel interfaces: tick input, result output, configuration writes
`default_nettype none

interface wrd_in_if import wrd_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               cmd;
  logic [INST_W-1:0]  tick_instrument;
  logic [TIME_W-1:0]  tick_time_ms;
  logic [PRICE_W-1:0] price;

  modport source (output valid, output cmd, output tick_instrument,
                  output tick_time_ms, output price, input ready);
  modport sink   (input valid, input cmd, input tick_instrument,
                  input tick_time_ms, input price, output ready);
endinterface

interface wrd_out_if import wrd_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               order_fire;
  logic [PRICE_W-1:0] order_price;
  logic [PRICE_W-1:0] low_seen;
  logic               tick_ignored;
  logic               overflow;

  modport source (output valid, output order_fire, output order_price,
                  output low_seen, output tick_ignored, output overflow,
                  input ready);
  modport sink   (input valid, input order_fire, input order_price,
                  input low_seen, input tick_ignored, input overflow,
                  output ready);
endinterface

interface wrd_cfg_if import wrd_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> src/wrd_store.sv
// tick window memory: one write port, one registered read port
`default_nettype none

module wrd_store import wrd_pkg::*; #(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  logic        clk,
  input  logic        wr_en,
  input  logic [AW-1:0] wr_addr,
  input  tick_entry_t wr_data,
  input  logic [AW-1:0] rd_addr,
  output tick_entry_t rd_data
);

  tick_entry_t mem [DEPTH];
  tick_entry_t rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

>>> src/window_rise_detector_core.sv
// Window rise detector top level: microcoded sequencer over a tick window memory.
// A reload item clears the window and an item for another instrument is ignored; a matching
// tick expires old entries, stores itself and, unless orders are held, scans the window,
// each entry taking a read step and a check step through the single registered memory read port.
// One item at a time; the next is taken in the cycle after the result is registered.
// Reset (rst_n low, synchronous) empties the window and restores register defaults.
`default_nettype none

module window_rise_detector_core import wrd_pkg::*; #(
  parameter int STORE_DEPTH = 256
) (
  input  logic      clk,
  input  logic      rst_n,
  wrd_cfg_if.sink   cfg_wr,
  wrd_in_if.sink    in_item,
  wrd_out_if.source out_item
);

  localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int CW = $clog2(STORE_DEPTH + 1);
  localparam int SW = AW + 1;

  // wrap a slot sum below twice the depth back into range
  function automatic logic [AW-1:0] wrap_slot(input logic [SW-1:0] s);
    logic [SW-1:0] d;
    d = s - SW'(STORE_DEPTH);
    return (s >= SW'(STORE_DEPTH)) ? d[AW-1:0] : s[AW-1:0];
  endfunction

  // sequencer
  step_t      pc_r, pc_nxt;
  ctrl_word_t cw;
  logic       jump;

  // configuration registers
  logic [INST_W-1:0]  inst_code_r;
  logic [TIME_W-1:0]  span_r;
  logic [PRICE_W-1:0] thr_r;
  logic [PRICE_W-1:0] init_low_r;
  logic               hold_r;

  // latched item and working values
  logic               cmd_r;
  logic [INST_W-1:0]  inst_r;
  logic [TIME_W-1:0]  now_r;
  logic [PRICE_W-1:0] px_r;
  logic [AW-1:0]      oldest_r;
  logic [CW-1:0]      count_r;
  logic [CW-1:0]      k_r;
  logic [PRICE_W-1:0] low_r;
  logic               fire_r;
  logic               ign_r;
  logic               ovf_r;

  // output register
  logic               out_valid_r;
  logic               out_fire_r;
  logic [PRICE_W-1:0] out_price_r;
  logic [PRICE_W-1:0] out_low_r;
  logic               out_ign_r;
  logic               out_ovf_r;

  // memory port signals
  logic        wr_en;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_addr;
  tick_entry_t wr_data;
  tick_entry_t rd_data;

  logic          in_acc;
  logic          out_free;
  logic          empty;
  logic          full;
  logic          expired;
  logic          same_time;
  logic          fire_now;
  logic [PRICE_W-1:0] new_low;
  logic [AW-1:0] slot_next;
  logic [AW-1:0] slot_newest;
  logic [AW-1:0] slot_append;
  logic [AW-1:0] slot_scan;

  assign cw       = ucode(pc_r);
  assign in_acc   = in_item.valid && in_item.ready;
  assign out_free = !out_valid_r || out_item.ready;
  assign empty    = (count_r == '0);
  assign full     = (count_r == CW'(STORE_DEPTH));

  // slot arithmetic
  assign slot_next   = wrap_slot(SW'(oldest_r) + SW'(1));
  assign slot_newest = wrap_slot(SW'(oldest_r) + SW'(count_r) - SW'(1));
  assign slot_append = wrap_slot(SW'(oldest_r) + SW'(count_r));
  assign slot_scan   = wrap_slot(SW'(oldest_r) + SW'(k_r));

  // comparisons on the entry just read
  assign expired   = (now_r >= rd_data.tick_time) &&
                     ((now_r - rd_data.tick_time) > span_r);
  assign same_time = (rd_data.tick_time == now_r);
  assign new_low   = (rd_data.tick_price < low_r) ? rd_data.tick_price : low_r;
  assign fire_now  = (rd_data.tick_price - new_low) > thr_r;

  // jump condition select
  always_comb begin
    case (cw.cond)
      C_NEVER:     jump = 1'b0;
      C_ALWAYS:    jump = 1'b1;
      C_NO_ITEM:   jump = !in_item.valid;
      C_RELOAD:    jump = cmd_r;
      C_MISMATCH:  jump = (inst_r != inst_code_r);
      C_EMPTY:     jump = empty;
      C_EXPIRED:   jump = expired;
      C_SAME_TIME: jump = same_time;
      C_HOLD:      jump = hold_r;
      C_SCAN_END:  jump = (k_r == count_r);
      C_NO_FIRE:   jump = !fire_now;
      C_OUT_BUSY:  jump = !out_free;
      default:     jump = 1'b1;
    endcase
    pc_nxt = jump ? cw.target : step_t'(pc_r + step_t'(1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= S_WAIT;
    end else begin
      pc_r <= pc_nxt;
    end
  end

  // memory address and write select
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = slot_append;
    rd_addr = oldest_r;
    case (cw.op)
      OP_RD_NEW:    rd_addr = slot_newest;
      OP_RD_SCAN:   rd_addr = slot_scan;
      OP_APPEND: begin
        wr_en   = 1'b1;
        wr_addr = full ? oldest_r : slot_append;
      end
      OP_OVERWRITE: begin
        wr_en   = 1'b1;
        wr_addr = slot_newest;
      end
      default: ;
    endcase
  end

  assign wr_data = '{tick_time: now_r, tick_price: px_r};

  wrd_store #(
    .DEPTH (STORE_DEPTH),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // configuration registers; reload clears the hold flag
  assign cfg_wr.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inst_code_r <= '0;
      span_r      <= SPAN_RESET;
      thr_r       <= THRESHOLD_RESET;
      init_low_r  <= INIT_LOW_RESET;
      hold_r      <= 1'b0;
    end else begin
      if (cfg_wr.valid) begin
        case (cfg_wr.index)
          REG_INSTRUMENT_CODE: inst_code_r <= cfg_wr.data[INST_W-1:0];
          REG_WINDOW_SPAN_MS:  span_r      <= cfg_wr.data[TIME_W-1:0];
          REG_RISE_THRESHOLD:  thr_r       <= cfg_wr.data[PRICE_W-1:0];
          REG_INITIAL_LOW:     init_low_r  <= cfg_wr.data[PRICE_W-1:0];
          default: ;
        endcase
      end
      if (cw.op == OP_CLEAR) begin
        hold_r <= 1'b0;
      end else if (cfg_wr.valid && cfg_wr.index == REG_HOLD_ORDERS) begin
        hold_r <= cfg_wr.data[0];
      end
    end
  end

  // window pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oldest_r <= '0;
      count_r  <= '0;
    end else begin
      case (cw.op)
        OP_CLEAR: begin
          oldest_r <= '0;
          count_r  <= '0;
        end
        OP_POP: begin
          if (expired) begin
            oldest_r <= slot_next;
            count_r  <= count_r - CW'(1);
          end
        end
        OP_APPEND: begin
          if (full) begin
            oldest_r <= slot_next;
          end else begin
            count_r <= count_r + CW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // item latch, scan state and result flags
  always_ff @(posedge clk) begin
    case (cw.op)
      OP_LATCH: begin
        if (in_acc) begin
          cmd_r  <= in_item.cmd;
          inst_r <= in_item.tick_instrument;
          now_r  <= in_item.tick_time_ms;
          px_r   <= in_item.price;
          low_r  <= '0;
          fire_r <= 1'b0;
          ign_r  <= 1'b0;
          ovf_r  <= 1'b0;
        end
      end
      OP_APPEND: begin
        if (full) begin
          ovf_r <= 1'b1;
        end
      end
      OP_SCAN_INIT: begin
        k_r   <= '0;
        low_r <= hold_r ? '0 : init_low_r;
      end
      OP_RD_SCAN: k_r <= k_r + CW'(1);
      OP_SCAN_STEP: begin
        low_r <= new_low;
        if (fire_now) begin
          fire_r <= 1'b1;
        end
      end
      OP_IGNORE: ign_r <= 1'b1;
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cw.op == OP_EMIT && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_item.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cw.op == OP_EMIT && out_free) begin
      out_fire_r  <= fire_r;
      out_price_r <= fire_r ? px_r : '0;
      out_low_r   <= low_r;
      out_ign_r   <= ign_r;
      out_ovf_r   <= ovf_r;
    end
  end

  assign in_item.ready         = (pc_r == S_WAIT);
  assign out_item.valid        = out_valid_r;
  assign out_item.order_fire   = out_fire_r;
  assign out_item.order_price  = out_price_r;
  assign out_item.low_seen     = out_low_r;
  assign out_item.tick_ignored = out_ign_r;
  assign out_item.overflow     = out_ovf_r;

endmodule

`default_nettype wire

>>> src/wrd_checker.sv
// port-level checks of the window rise detector and their bind
`default_nettype none

module wrd_checker import wrd_pkg::*; (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_ready,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire logic               order_fire,
  input wire logic [PRICE_W-1:0] order_price,
  input wire logic [PRICE_W-1:0] low_seen,
  input wire logic               tick_ignored,
  input wire logic               overflow
);

  // a pending result is not withdrawn
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before it was taken");

  // one item in work at a time
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second item taken while one is in work");

  // no order, no order price
  a_no_price: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !order_fire |-> order_price == '0)
    else $error("order price set without an order");

  // an ignored tick leaves no trace
  a_ignored: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && tick_ignored |-> !order_fire && !overflow && low_seen == '0)
    else $error("ignored tick reports window activity");

endmodule

bind window_rise_detector_core wrd_checker u_wrd_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_item.valid),
  .in_ready     (in_item.ready),
  .out_valid    (out_item.valid),
  .out_ready    (out_item.ready),
  .order_fire   (out_item.order_fire),
  .order_price  (out_item.order_price),
  .low_seen     (out_item.low_seen),
  .tick_ignored (out_item.tick_ignored),
  .overflow     (out_item.overflow)
);

`default_nettype wire
